### hdl/ordered_run_queue_defines.svh
// Assertion macros used by the ordered run queue checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ORDERED_RUN_QUEUE_DEFINES_SVH
`define ORDERED_RUN_QUEUE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define ORQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ordered_run_queue: same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define ORQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ordered_run_queue: next-cycle check failed");

`endif

### hdl/orq_pkg.sv
// Shared types and constants of the ordered run queue.
// Used by orq_ctrl, orq_datapath, orq_checker and the top level; depends on nothing.
package orq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int ID_BITS     = 8;
	localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int KEY_W       = 32;
	localparam int ID_W        = 8;
	localparam logic [ID_W-1:0] ID_MASK = ID_W'((64'd1 << ID_BITS) - 64'd1);

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_SEARCH = 2'd2,
		KIND_LEFT   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_DONE = 2'd0,
		STATUS_DUP  = 2'd1,
		STATUS_FULL = 2'd2,
		STATUS_MISS = 2'd3
	} status_t;

	// Memory read address source
	typedef enum logic [1:0] {
		RD_POS  = 2'd0,
		RD_DOWN = 2'd1,
		RD_UP   = 2'd2
	} rd_sel_t;

	// Result register source
	typedef enum logic [1:0] {
		RES_RD   = 2'd0,
		RES_IN   = 2'd1,
		RES_ZERO = 2'd2
	} res_src_t;

	typedef struct packed {
		logic     latch_in;
		logic     pos_clr;
		logic     pos_inc;
		logic     idx_ld_cnt;
		logic     idx_ld_pos;
		logic     idx_inc;
		logic     idx_dec;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     wr_en;
		logic     wr_new;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     res_ld;
		res_src_t res_src;
		status_t  res_status;
		logic     out_ld;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  less;
		logic  equal;
		logic  pos_end;
		logic  cnt_zero;
		logic  cnt_full;
		logic  idx_eq_pos;
		logic  idx_last;
		logic  out_free;
	} stat_t;

endpackage

### hdl/ordered_run_queue.sv
// Ordered run queue: up to 64 entries of signed 32-bit key and 8-bit task id,
// kept in ascending key order, each key unique.
//
// Input channel (in_valid, in_stall, kind, key, task_id): one operation per
// transfer: insert, remove, search by key, or report the smallest entry.
// Output channel (out_valid, out_stall, status, found_key, found_id): exactly
// one result per operation, in order.
// Operations are handled one at a time. The controller scans the entry memory
// from the smallest key, reading and then comparing each entry passed
// (S_SCAN, S_CHECK). An insert or remove then shifts entries, each read and
// then written back (S_SHUP_RD/S_SHUP_WR, S_SHDN_RD/S_SHDN_WR), through the
// one read port and the one write port of that memory.
// in_stall is high from the cycle after a transfer until the result has been
// moved to the output register. A stalled result holds in that register while
// the next operation is already accepted and processed; it waits only to hand
// its own result over.
// Reset empties the queue at once (entry count to zero); no clearing pass.
module ordered_run_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        kind,
	input  logic signed [orq_pkg::KEY_W-1:0]  key,
	input  logic [orq_pkg::ID_W-1:0]          task_id,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic signed [orq_pkg::KEY_W-1:0]  found_key,
	output logic [orq_pkg::ID_W-1:0]          found_id
);

	orq_pkg::cmd_t  cmd;
	orq_pkg::stat_t stat;
	logic           busy;
	logic           in_accept;

	assign in_stall  = busy;
	assign in_accept = in_valid && !busy;

	orq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy)
	);

	orq_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.kind      (kind),
		.key       (key),
		.task_id   (task_id),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.found_key (found_key),
		.found_id  (found_id)
	);

endmodule

### hdl/orq_ctrl.sv
// Controller of the ordered run queue: sequences scan, shift and result steps.
// Depends on orq_pkg; drives orq_datapath through cmd_t and reads stat_t.
module orq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_accept,
	input  orq_pkg::stat_t stat,
	output orq_pkg::cmd_t  cmd,
	output logic           busy
);

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_SCAN    = 9'b000000010,
		S_CHECK   = 9'b000000100,
		S_SHUP_RD = 9'b000001000,
		S_SHUP_WR = 9'b000010000,
		S_WRNEW   = 9'b000100000,
		S_SHDN_RD = 9'b001000000,
		S_SHDN_WR = 9'b010000000,
		S_RESP    = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   decide;
	logic   hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		decide  = 1'b0;
		hit     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					cmd.latch_in = 1'b1;
					cmd.pos_clr  = 1'b1;
					state_d      = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.kind == orq_pkg::KIND_LEFT) begin
					if (stat.cnt_zero) begin
						cmd.res_ld     = 1'b1;
						cmd.res_src    = orq_pkg::RES_ZERO;
						cmd.res_status = orq_pkg::STATUS_MISS;
						state_d        = S_RESP;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = orq_pkg::RD_POS;
						state_d    = S_CHECK;
					end
				end else if (stat.pos_end) begin
					decide = 1'b1;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = orq_pkg::RD_POS;
					state_d    = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.kind == orq_pkg::KIND_LEFT) begin
					cmd.res_ld     = 1'b1;
					cmd.res_src    = orq_pkg::RES_RD;
					cmd.res_status = orq_pkg::STATUS_DONE;
					state_d        = S_RESP;
				end else if (stat.less) begin
					cmd.pos_inc = 1'b1;
					state_d     = S_SCAN;
				end else begin
					decide = 1'b1;
					hit    = stat.equal;
				end
			end
			S_SHUP_RD: begin
				if (stat.idx_eq_pos) begin
					state_d = S_WRNEW;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = orq_pkg::RD_DOWN;
					state_d    = S_SHUP_WR;
				end
			end
			S_SHUP_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.idx_dec = 1'b1;
				state_d     = S_SHUP_RD;
			end
			S_WRNEW: begin
				cmd.wr_en      = 1'b1;
				cmd.wr_new     = 1'b1;
				cmd.cnt_inc    = 1'b1;
				cmd.res_ld     = 1'b1;
				cmd.res_src    = orq_pkg::RES_IN;
				cmd.res_status = orq_pkg::STATUS_DONE;
				state_d        = S_RESP;
			end
			S_SHDN_RD: begin
				if (stat.idx_last) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_RESP;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = orq_pkg::RD_UP;
					state_d    = S_SHDN_WR;
				end
			end
			S_SHDN_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d     = S_SHDN_RD;
			end
			S_RESP: begin
				// hold the result until the output register is free
				if (stat.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// The scan has reached the insertion point: act on the operation.
		if (decide) begin
			cmd.res_ld = 1'b1;
			unique case (stat.kind)
				orq_pkg::KIND_INSERT: begin
					if (hit) begin
						cmd.res_src    = orq_pkg::RES_RD;
						cmd.res_status = orq_pkg::STATUS_DUP;
						state_d        = S_RESP;
					end else if (stat.cnt_full) begin
						cmd.res_src    = orq_pkg::RES_ZERO;
						cmd.res_status = orq_pkg::STATUS_FULL;
						state_d        = S_RESP;
					end else begin
						cmd.res_ld     = 1'b0;
						cmd.idx_ld_cnt = 1'b1;
						state_d        = S_SHUP_RD;
					end
				end
				orq_pkg::KIND_REMOVE: begin
					if (hit) begin
						cmd.res_src    = orq_pkg::RES_RD;
						cmd.res_status = orq_pkg::STATUS_DONE;
						cmd.idx_ld_pos = 1'b1;
						state_d        = S_SHDN_RD;
					end else begin
						cmd.res_src    = orq_pkg::RES_ZERO;
						cmd.res_status = orq_pkg::STATUS_MISS;
						state_d        = S_RESP;
					end
				end
				default: begin
					if (hit) begin
						cmd.res_src    = orq_pkg::RES_RD;
						cmd.res_status = orq_pkg::STATUS_DONE;
					end else begin
						cmd.res_src    = orq_pkg::RES_ZERO;
						cmd.res_status = orq_pkg::STATUS_MISS;
					end
					state_d = S_RESP;
				end
			endcase
		end
	end

endmodule

### hdl/orq_datapath.sv
// Datapath of the ordered run queue: entry memory, scan and shift indexes,
// entry count, result and output registers. Depends on orq_pkg.
module orq_datapath (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  orq_pkg::cmd_t                            cmd,
	output orq_pkg::stat_t                           stat,
	input  logic [1:0]                               kind,
	input  logic signed [orq_pkg::KEY_W-1:0]         key,
	input  logic [orq_pkg::ID_W-1:0]                 task_id,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic [1:0]                               status,
	output logic signed [orq_pkg::KEY_W-1:0]         found_key,
	output logic [orq_pkg::ID_W-1:0]                 found_id
);

	localparam int ENTRY_W = orq_pkg::KEY_W + orq_pkg::ID_W;

	logic [ENTRY_W-1:0] entry_mem_q [orq_pkg::QUEUE_DEPTH];

	orq_pkg::kind_t                   op_kind_q;
	logic signed [orq_pkg::KEY_W-1:0] op_key_q;
	logic [orq_pkg::ID_W-1:0]         op_id_q;

	logic [orq_pkg::CNT_W-1:0] pos_q;
	logic [orq_pkg::CNT_W-1:0] idx_q;
	logic [orq_pkg::CNT_W-1:0] cnt_q;
	logic [orq_pkg::CNT_W-1:0] idx_m1;
	logic [orq_pkg::CNT_W-1:0] idx_p1;

	logic signed [orq_pkg::KEY_W-1:0] rd_key_q;
	logic [orq_pkg::ID_W-1:0]         rd_id_q;

	logic [orq_pkg::ADDR_W-1:0] rd_addr;
	logic [orq_pkg::ADDR_W-1:0] wr_addr;
	logic [ENTRY_W-1:0]         wr_data;

	orq_pkg::status_t                 res_status_q;
	logic signed [orq_pkg::KEY_W-1:0] res_key_q;
	logic [orq_pkg::ID_W-1:0]         res_id_q;

	orq_pkg::status_t                 out_status_q;
	logic signed [orq_pkg::KEY_W-1:0] out_key_q;
	logic [orq_pkg::ID_W-1:0]         out_id_q;
	logic                             out_valid_q;

	assign idx_m1 = idx_q - 1'b1;
	assign idx_p1 = idx_q + 1'b1;

	always_comb begin
		case (cmd.rd_sel)
			orq_pkg::RD_DOWN: rd_addr = idx_m1[orq_pkg::ADDR_W-1:0];
			orq_pkg::RD_UP:   rd_addr = idx_p1[orq_pkg::ADDR_W-1:0];
			default:          rd_addr = pos_q[orq_pkg::ADDR_W-1:0];
		endcase
	end

	assign wr_addr = cmd.wr_new ? pos_q[orq_pkg::ADDR_W-1:0] : idx_q[orq_pkg::ADDR_W-1:0];
	assign wr_data = cmd.wr_new ? {op_key_q, op_id_q} : {rd_key_q, rd_id_q};

	// Entry memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			entry_mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			{rd_key_q, rd_id_q} <= entry_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_kind_q <= orq_pkg::kind_t'(kind);
			op_key_q  <= key;
			op_id_q   <= task_id & orq_pkg::ID_MASK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			idx_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.pos_clr) begin
				pos_q <= '0;
			end else if (cmd.pos_inc) begin
				pos_q <= pos_q + 1'b1;
			end
			if (cmd.idx_ld_cnt) begin
				idx_q <= cnt_q;
			end else if (cmd.idx_ld_pos) begin
				idx_q <= pos_q;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_p1;
			end else if (cmd.idx_dec) begin
				idx_q <= idx_m1;
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_ld) begin
			res_status_q <= cmd.res_status;
			case (cmd.res_src)
				orq_pkg::RES_RD: begin
					res_key_q <= rd_key_q;
					res_id_q  <= rd_id_q;
				end
				orq_pkg::RES_IN: begin
					res_key_q <= op_key_q;
					res_id_q  <= op_id_q;
				end
				default: begin
					res_key_q <= '0;
					res_id_q  <= '0;
				end
			endcase
		end
		if (cmd.out_ld) begin
			out_status_q <= res_status_q;
			out_key_q    <= res_key_q;
			out_id_q     <= res_id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign found_key = out_key_q;
	assign found_id  = out_id_q;

	always_comb begin
		stat.kind       = op_kind_q;
		stat.less       = (rd_key_q < op_key_q);
		stat.equal      = (rd_key_q == op_key_q);
		stat.pos_end    = (pos_q == cnt_q);
		stat.cnt_zero   = (cnt_q == '0);
		stat.cnt_full   = (cnt_q == orq_pkg::CNT_W'(orq_pkg::QUEUE_DEPTH));
		stat.idx_eq_pos = (idx_q == pos_q);
		stat.idx_last   = (idx_p1 >= cnt_q);
		stat.out_free   = !out_valid_q || !out_stall;
	end

endmodule

### hdl/orq_checker.sv
// Port-level checks of the ordered run queue, bound to the top level.
// Depends on ordered_run_queue_defines.svh and orq_pkg.
`include "ordered_run_queue_defines.svh"

module orq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [1:0]                        status,
	input logic signed [orq_pkg::KEY_W-1:0]  found_key,
	input logic [orq_pkg::ID_W-1:0]          found_id
);

	// A transfer in makes the block busy in the following cycle.
	`ORQ_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall)

	// A new result appears only as the block leaves its busy period.
	`ORQ_ASSERT_NOW(a_result_ends_busy, $rose(out_valid), $past(in_stall) && !in_stall)

	// Miss, empty and full results carry zero payload.
	`ORQ_ASSERT_NOW(a_zero_payload,
		out_valid && (status == orq_pkg::STATUS_MISS || status == orq_pkg::STATUS_FULL),
		found_key == '0 && found_id == '0)

	// A stalled result holds.
	`ORQ_ASSERT_NEXT(a_stalled_result_holds, out_valid && out_stall,
		out_valid && $stable(status) && $stable(found_key) && $stable(found_id))

endmodule

bind ordered_run_queue orq_checker u_orq_checker (.*);
